// ----- hw/rtl/ges_pkg.sv -----
// Shared constants, state codes and controller/datapath interface types
// for the goodness epoch scheduler. No dependencies.
package ges_pkg;

    localparam int NUM_PROCS = 32;
    localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

    typedef logic [PW-1:0] t_idx;
    typedef logic [1:0]    t_state;

    localparam t_state ST_FREE    = 2'd0;
    localparam t_state ST_READY   = 2'd1;
    localparam t_state ST_CURRENT = 2'd2;
    localparam t_state ST_BLOCKED = 2'd3;

    typedef struct packed {
        logic load;
        logic upd_wr;
        logic dec_rd;
        logic dec_cap;
        logic dec_wr;
        logic sweep_init;
        logic sweep_rd;
        logic epoch;
        logic wr_old;
        logic wr_new;
        logic res_load;
    } t_dp_cmd;

    typedef struct packed {
        logic seen;
        logic found;
        logic sweep_last;
        logic no_switch;
    } t_dp_status;

endpackage

// ----- hw/rtl/ges_ctrl.sv -----
// Sequencing state machine of the goodness epoch scheduler.
// Depends on ges_pkg for the command and status types.
module ges_ctrl import ges_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_kind,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_res_valid
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_DEC_RD,
        S_DEC_WR,
        S_SWEEP,
        S_DRAIN,
        S_EVAL,
        S_SEL,
        S_WR_OLD,
        S_WR_NEW
    } t_ctrl_state;

    t_ctrl_state r_state;
    logic        r_res_vld;
    logic        r_dec_en;
    logic        r_epoch_pend;
    logic        r_epoch_run;
    logic        r_pass;
    logic        retry;

    assign retry = (r_state == S_EVAL) && i_status.seen && !i_status.found && !r_pass;

    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = (r_state == S_IDLE) && i_start;
        o_cmd.upd_wr     = (r_state == S_UPD);
        o_cmd.dec_rd     = (r_state == S_DEC_RD);
        o_cmd.dec_cap    = (r_state == S_DEC_WR);
        o_cmd.dec_wr     = (r_state == S_DEC_WR) && r_dec_en;
        o_cmd.sweep_init = (r_state == S_DEC_WR) || retry;
        o_cmd.sweep_rd   = (r_state == S_SWEEP);
        o_cmd.epoch      = r_epoch_run;
        o_cmd.wr_old     = (r_state == S_WR_OLD);
        o_cmd.wr_new     = (r_state == S_WR_NEW);
        o_cmd.res_load   = ((r_state == S_SEL) && i_status.no_switch) ||
                           (r_state == S_WR_NEW);
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_res_vld    <= 1'b0;
            r_dec_en     <= 1'b1;
            r_epoch_pend <= 1'b1;
            r_epoch_run  <= 1'b0;
            r_pass       <= 1'b0;
        end else begin
            r_res_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= i_kind ? S_DEC_RD : S_UPD;
                    end
                end
                S_UPD: begin
                    r_state <= S_IDLE;
                end
                S_DEC_RD: begin
                    r_state <= S_DEC_WR;
                end
                S_DEC_WR: begin
                    r_epoch_run  <= r_epoch_pend;
                    r_epoch_pend <= 1'b0;
                    r_pass       <= 1'b0;
                    r_state      <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (i_status.sweep_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (!i_status.seen) begin
                        r_epoch_pend <= 1'b1;
                        r_state      <= S_SEL;
                    end else if (i_status.found) begin
                        r_state <= S_SEL;
                    end else if (!r_pass) begin
                        r_epoch_run <= 1'b1;
                        r_dec_en    <= 1'b0;
                        r_pass      <= 1'b1;
                        r_state     <= S_SWEEP;
                    end else begin
                        r_epoch_pend <= 1'b1;
                        r_dec_en     <= 1'b0;
                        r_state      <= S_SEL;
                    end
                end
                S_SEL: begin
                    if (i_status.no_switch) begin
                        r_res_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_state <= S_WR_OLD;
                    end
                end
                S_WR_OLD: begin
                    r_state <= S_WR_NEW;
                end
                S_WR_NEW: begin
                    r_dec_en  <= 1'b1;
                    r_res_vld <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/ges_dp.sv -----
// Datapath of the goodness epoch scheduler: process table memories, time
// accounting, epoch refresh and goodness search. Depends on ges_pkg.
module ges_dp import ges_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [4:0]  i_pid,
    input  logic [1:0]  i_proc_state,
    input  logic [6:0]  i_priority_req,
    input  logic [31:0] i_now_ms,
    output t_dp_status  o_status,
    output logic [4:0]  o_previous_pid,
    output logic [4:0]  o_next_pid,
    output logic        o_switched
);

    t_state     r_mem_st [NUM_PROCS];
    logic [6:0] r_mem_pr [NUM_PROCS];
    logic [7:0] r_mem_c  [NUM_PROCS];
    logic [7:0] r_mem_q  [NUM_PROCS];

    logic [NUM_PROCS-1:0] r_v_st, r_v_pr, r_v_c, r_v_q;

    t_state     r_rd_st;
    logic [6:0] r_rd_pr;
    logic [7:0] r_rd_c, r_rd_q;
    logic       r_rdv_st, r_rdv_pr, r_rdv_c, r_rdv_q, r_rd_zero;

    logic [4:0]  r_pid;
    t_state      r_st;
    logic [6:0]  r_prio;
    logic [31:0] r_now;

    t_idx        r_cur, r_best, r_idx, r_pend_idx;
    t_state      r_cur_state;
    logic        r_pend, r_seen, r_found;
    logic [8:0]  r_best_g;
    logic [31:0] r_last;
    logic        r_started;
    logic [4:0]  r_prev, r_next;
    logic        r_sw;

    t_idx        rd_addr, wa;
    logic        rd_en;
    logic        we_st, we_pr, we_c, we_q;
    t_state      wd_st;
    logic [7:0]  wd_c, wd_q;
    t_state      rs;
    logic [6:0]  rp;
    logic [7:0]  rc, rq;
    logic [PW+4:0] pid_ext, cur_ext, best_ext;
    logic        pid_ok;
    logic [31:0] eff_last, diff;
    logic [7:0]  dec_val;
    logic [8:0]  q_sum;
    logic [7:0]  q_sat, c2, q2;
    logic        epoch_do, searchable;
    logic [8:0]  g;
    logic        no_switch;

    assign rs = r_rdv_st ? r_rd_st : (r_rd_zero ? ST_CURRENT : ST_FREE);
    assign rp = r_rdv_pr ? r_rd_pr : 7'd1;
    assign rc = r_rdv_c ? r_rd_c : 8'd0;
    assign rq = r_rdv_q ? r_rd_q : 8'd0;

    assign pid_ext  = {{PW{1'b0}}, r_pid};
    assign pid_ok   = pid_ext < (PW+5)'(NUM_PROCS);
    assign cur_ext  = {5'd0, r_cur};
    assign best_ext = {5'd0, r_best};

    assign eff_last = r_started ? r_last : r_now;
    assign diff     = r_now - eff_last;
    assign dec_val  = (diff >= {24'd0, rc}) ? 8'd0 : rc - diff[7:0];

    assign q_sum      = {2'b00, rc[7:1]} + {2'b00, rp};
    assign q_sat      = q_sum[8] ? 8'hFF : q_sum[7:0];
    assign epoch_do   = i_cmd.epoch && (rs != ST_FREE);
    assign c2         = epoch_do ? q_sat : rc;
    assign q2         = epoch_do ? q_sat : rq;
    assign searchable = (rs == ST_READY) || (rs == ST_CURRENT);
    assign g          = ((c2 != 8'd0) && (q2 != 8'd0)) ? ({1'b0, c2} + {2'b00, rp}) : 9'd0;

    assign no_switch = (r_best == r_cur) && (r_cur_state == ST_CURRENT);

    assign rd_addr = i_cmd.dec_rd ? r_cur : r_idx;
    assign rd_en   = i_cmd.dec_rd || i_cmd.sweep_rd;

    always_comb begin
        wa    = r_cur;
        we_st = 1'b0;
        we_pr = 1'b0;
        we_c  = 1'b0;
        we_q  = 1'b0;
        wd_st = r_st;
        wd_c  = 8'd0;
        wd_q  = 8'd0;
        if (i_cmd.upd_wr) begin
            wa    = pid_ext[PW-1:0];
            we_st = pid_ok;
            we_pr = pid_ok;
            we_c  = pid_ok && (r_st == ST_FREE);
            we_q  = pid_ok && (r_st == ST_FREE);
        end else if (i_cmd.dec_wr) begin
            we_c = 1'b1;
            wd_c = dec_val;
        end else if (r_pend) begin
            wa   = r_pend_idx;
            we_c = epoch_do;
            we_q = epoch_do;
            wd_c = q_sat;
            wd_q = q_sat;
        end else if (i_cmd.wr_old) begin
            we_st = (r_cur_state == ST_CURRENT);
            wd_st = ST_READY;
        end else if (i_cmd.wr_new) begin
            wa    = r_best;
            we_st = 1'b1;
            wd_st = ST_CURRENT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_st) r_mem_st[wa] <= wd_st;
        if (we_pr) r_mem_pr[wa] <= r_prio;
        if (we_c)  r_mem_c[wa]  <= wd_c;
        if (we_q)  r_mem_q[wa]  <= wd_q;
        if (rd_en) begin
            r_rd_st <= r_mem_st[rd_addr];
            r_rd_pr <= r_mem_pr[rd_addr];
            r_rd_c  <= r_mem_c[rd_addr];
            r_rd_q  <= r_mem_q[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_st    <= '0;
            r_v_pr    <= '0;
            r_v_c     <= '0;
            r_v_q     <= '0;
            r_cur     <= '0;
            r_last    <= '0;
            r_started <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            if (we_st) r_v_st[wa] <= 1'b1;
            if (we_pr) r_v_pr[wa] <= 1'b1;
            if (we_c)  r_v_c[wa]  <= 1'b1;
            if (we_q)  r_v_q[wa]  <= 1'b1;
            if (rd_en) begin
                r_rdv_st  <= r_v_st[rd_addr];
                r_rdv_pr  <= r_v_pr[rd_addr];
                r_rdv_c   <= r_v_c[rd_addr];
                r_rdv_q   <= r_v_q[rd_addr];
                r_rd_zero <= (rd_addr == '0);
            end
            if (i_cmd.dec_cap) begin
                r_started <= 1'b1;
                if (!r_started || i_cmd.dec_wr) begin
                    r_last <= r_now;
                end
            end
            if (i_cmd.wr_new) begin
                r_cur <= r_best;
            end
            r_pend <= i_cmd.sweep_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pid  <= i_pid;
            r_st   <= i_proc_state;
            r_prio <= i_priority_req;
            r_now  <= i_now_ms;
        end
        if (i_cmd.dec_cap) begin
            r_cur_state <= rs;
        end
        if (i_cmd.sweep_rd) begin
            r_pend_idx <= r_idx;
            r_idx      <= r_idx + 1'b1;
        end
        if (i_cmd.sweep_init) begin
            r_idx    <= t_idx'(1);
            r_seen   <= 1'b0;
            r_found  <= 1'b0;
            r_best_g <= '0;
            r_best   <= '0;
        end else if (r_pend) begin
            if (epoch_do || searchable) begin
                r_seen <= 1'b1;
            end
            if (searchable && (g > r_best_g)) begin
                r_best_g <= g;
                r_best   <= r_pend_idx;
                r_found  <= 1'b1;
            end
        end
        if (i_cmd.res_load) begin
            r_prev <= cur_ext[4:0];
            r_next <= no_switch ? cur_ext[4:0] : best_ext[4:0];
            r_sw   <= !no_switch;
        end
    end

    assign o_status.seen       = r_seen;
    assign o_status.found      = r_found;
    assign o_status.sweep_last = (r_idx == t_idx'(NUM_PROCS - 1));
    assign o_status.no_switch  = no_switch;

    assign o_previous_pid = r_prev;
    assign o_next_pid     = r_next;
    assign o_switched     = r_sw;

endmodule

// ----- hw/rtl/goodness_epoch_scheduler.sv -----
// Top level of the goodness epoch scheduler: controller plus datapath.
// Depends on ges_pkg, ges_ctrl and ges_dp.
//
// A transaction is taken when start is high and busy is low. An update
// keeps busy high for one cycle and gives no result. A reschedule keeps
// busy high for a walk of the process table, and for a second walk when a
// forced epoch reruns the table pass; its length is set by the single read
// port of the process table, which the epoch refresh and goodness search
// walk one entry per cycle. The result appears for exactly one cycle with
// o_res_valid, in the first cycle in which busy is low again, and must be
// captured then, since the receiver cannot stall the block.
module goodness_epoch_scheduler import ges_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [4:0]  i_pid,
    input  logic [1:0]  i_proc_state,
    input  logic [6:0]  i_priority_req,
    input  logic [31:0] i_now_ms,
    output logic        o_res_valid,
    output logic [4:0]  o_previous_pid,
    output logic [4:0]  o_next_pid,
    output logic        o_switched
);

    t_dp_cmd    cmd;
    t_dp_status status;

    ges_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_kind      (i_kind),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_res_valid (o_res_valid)
    );

    ges_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_pid          (i_pid),
        .i_proc_state   (i_proc_state),
        .i_priority_req (i_priority_req),
        .i_now_ms       (i_now_ms),
        .o_status       (status),
        .o_previous_pid (o_previous_pid),
        .o_next_pid     (o_next_pid),
        .o_switched     (o_switched)
    );

endmodule

// ----- hw/rtl/ges_checker.sv -----
// Port-level checks for the goodness epoch scheduler and the bind that
// attaches them to the top level. Depends on goodness_epoch_scheduler.
module ges_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_res_valid,
    input logic [4:0]  o_previous_pid,
    input logic [4:0]  o_next_pid,
    input logic        o_switched
);

    logic [4:0] r_last_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_next <= 5'd0;
        end else if (o_res_valid) begin
            r_last_next <= o_next_pid;
        end
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted transaction");

    a_res_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy))
        else $error("result strobe without preceding busy cycle");

    a_res_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe held for more than one cycle");

    a_no_switch_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_switched) |-> (o_next_pid == o_previous_pid))
        else $error("next pid differs from previous pid without a switch");

    a_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_previous_pid == r_last_next))
        else $error("previous pid does not match the last chosen process");

endmodule

bind goodness_epoch_scheduler ges_checker u_ges_checker (.*);

// ----- bench/tb.sv -----
// Self-checking testbench for goodness_epoch_scheduler: a directed table, then random
// update and reschedule transactions; each reschedule result is checked against a
// behavioral scheduler model. Depends on ges_pkg and the goodness_epoch_scheduler RTL.
module tb import ges_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic K_UPDATE  = 1'b0;
    localparam logic K_RESCHED = 1'b1;
    localparam int   N_DIR     = 25;
    localparam int   N_PHASE   = 3;
    localparam int   PER_PHASE = 467;
    localparam int   MAX_GAP   = 24;
    localparam int   LIMIT     = 1_000_000;

    typedef struct packed {
        t_idx prev;
        t_idx next;
        logic sw;
    } t_pick;

    typedef struct packed {
        logic        kind;
        logic [4:0]  pid;
        t_state      st;
        logic [6:0]  prio;
        logic [31:0] now;
        logic        typed;
        t_pick       pick;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_kind = 1'b0;
    logic [4:0]  i_pid = '0;
    logic [1:0]  i_proc_state = '0;
    logic [6:0]  i_priority_req = '0;
    logic [31:0] i_now_ms = '0;
    logic        o_res_valid;
    logic [4:0]  o_previous_pid;
    logic [4:0]  o_next_pid;
    logic        o_switched;

    t_state      ps_state [NUM_PROCS];
    logic [6:0]  ps_prio  [NUM_PROCS];
    logic [7:0]  tick_cnt [NUM_PROCS];
    logic [7:0]  slice_q  [NUM_PROCS];
    t_idx        cur_pid;
    logic [31:0] last_ms;
    logic        clk_started;
    logic        charge_en;
    logic        epoch_due;

    t_pick       pending_picks [$];
    int          n_bad = 0;
    int          n_shown = 0;
    int          n_upd = 0;
    int          n_resched = 0;
    int          n_switch = 0;
    int          n_forced = 0;
    int          n_checked = 0;
    int          cycles = 0;

    goodness_epoch_scheduler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_pid          (i_pid),
        .i_proc_state   (i_proc_state),
        .i_priority_req (i_priority_req),
        .i_now_ms       (i_now_ms),
        .o_res_valid    (o_res_valid),
        .o_previous_pid (o_previous_pid),
        .o_next_pid     (o_next_pid),
        .o_switched     (o_switched)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, pending_picks.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_pick want;
        if (i_rst_n && o_res_valid) begin
            if (pending_picks.size() == 0) begin
                n_bad++;
                if (n_shown < 10) begin
                    n_shown++;
                    $display("Unexpected result: prev=%0d next=%0d sw=%0d",
                             o_previous_pid, o_next_pid, o_switched);
                end
            end else begin
                want = pending_picks.pop_front();
                n_checked++;
                if (o_previous_pid !== want.prev || o_next_pid !== want.next ||
                    o_switched !== want.sw) begin
                    n_bad++;
                    if (n_shown < 10) begin
                        n_shown++;
                        $display({"Mismatch: expected prev=%0d next=%0d sw=%0d, ",
                                  "got prev=%0d next=%0d sw=%0d"},
                                 want.prev, want.next, want.sw,
                                 o_previous_pid, o_next_pid, o_switched);
                    end
                end
            end
        end
    end

    // One reschedule of the scheduler model: charge time, refresh the epoch, search
    // for the best goodness, retry once after a forced epoch, then switch or stay put.
    task automatic predict_pick(input logic [31:0] now, output t_pick p);
        t_idx        cur_p;
        t_idx        best;
        logic        seen;
        logic        found;
        logic        done;
        int unsigned best_g;
        int unsigned g;
        int unsigned q;
        int          pass;
        int          i;
        cur_p = cur_pid;
        best  = '0;
        done  = 1'b0;
        for (pass = 0; pass < 2 && !done; pass++) begin
            seen   = 1'b0;
            found  = 1'b0;
            best_g = 0;
            if (!clk_started) begin
                last_ms     = now;
                clk_started = 1'b1;
            end
            if (charge_en) begin
                if (now - last_ms >= 32'(tick_cnt[cur_p])) begin
                    tick_cnt[cur_p] = '0;
                end else begin
                    tick_cnt[cur_p] = tick_cnt[cur_p] - 8'(now - last_ms);
                end
                last_ms = now;
            end
            if (epoch_due) begin
                for (i = 1; i < NUM_PROCS; i++) begin
                    if (ps_state[i] != ST_FREE) begin
                        q = 32'(tick_cnt[i]) / 2 + 32'(ps_prio[i]);
                        if (q > 255) begin
                            q = 255;
                        end
                        slice_q[i]  = 8'(q);
                        tick_cnt[i] = 8'(q);
                        seen        = 1'b1;
                    end
                end
                epoch_due = 1'b0;
            end
            for (i = 1; i < NUM_PROCS; i++) begin
                if (ps_state[i] == ST_READY || ps_state[i] == ST_CURRENT) begin
                    g = 0;
                    if (tick_cnt[i] != 0 && slice_q[i] != 0) begin
                        g = 32'(tick_cnt[i]) + 32'(ps_prio[i]);
                    end
                    seen = 1'b1;
                    if (g > best_g) begin
                        best_g = g;
                        best   = t_idx'(i);
                        found  = 1'b1;
                    end
                end
            end
            if (!seen) begin
                best      = '0;
                epoch_due = 1'b1;
                done      = 1'b1;
            end else if (found) begin
                done = 1'b1;
            end else begin
                epoch_due = 1'b1;
                charge_en = 1'b0;
                best      = '0;
                n_forced++;
            end
        end
        p.prev = cur_p;
        if (best == cur_p && ps_state[cur_p] == ST_CURRENT) begin
            p.next = cur_p;
            p.sw   = 1'b0;
        end else begin
            if (ps_state[cur_p] == ST_CURRENT) begin
                ps_state[cur_p] = ST_READY;
            end
            ps_state[best] = ST_CURRENT;
            cur_pid        = best;
            charge_en      = 1'b1;
            p.next         = best;
            p.sw           = 1'b1;
            n_switch++;
        end
    endtask

    task automatic offer(input t_stim_row r);
        t_pick p;
        start          <= 1'b1;
        i_kind         <= r.kind;
        i_pid          <= r.pid;
        i_proc_state   <= r.st;
        i_priority_req <= r.prio;
        i_now_ms       <= r.now;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        if (r.kind == K_UPDATE) begin
            n_upd++;
            ps_state[r.pid] = r.st;
            ps_prio[r.pid]  = r.prio;
            if (r.st == ST_FREE) begin
                tick_cnt[r.pid] = '0;
                slice_q[r.pid]  = '0;
            end
        end else begin
            n_resched++;
            predict_pick(r.now, p);
            if (r.typed) begin
                p = r.pick;
            end
            pending_picks.push_back(p);
        end
    endtask

    initial begin
        t_stim_row   dir_tab [N_DIR];
        t_stim_row   r;
        int          idle_pct [N_PHASE];
        int          ph;
        int          k;
        int          n_gap;
        int          sel;
        logic [31:0] sim_ms;

        dir_tab = '{
            '{K_RESCHED, 5'd0,  ST_FREE,    7'd0,   32'd0,         1'b1, '{5'd0, 5'd0, 1'b0}},
            '{K_UPDATE,  5'd31, ST_READY,   7'd127, 32'd0,         1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_UPDATE,  5'd1,  ST_READY,   7'd1,   32'd0,         1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_RESCHED, 5'd0,  ST_FREE,    7'd0,   32'd5,         1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_RESCHED, 5'd0,  ST_FREE,    7'd0,   32'd200,       1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_RESCHED, 5'd31, ST_BLOCKED, 7'd127, 32'hFFFF_FFFF, 1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_RESCHED, 5'd0,  ST_FREE,    7'd0,   32'd3,         1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_RESCHED, 5'd0,  ST_FREE,    7'd0,   32'd3,         1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_UPDATE,  5'd31, ST_BLOCKED, 7'd64,  32'd0,         1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_UPDATE,  5'd1,  ST_BLOCKED, 7'd64,  32'd0,         1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_RESCHED, 5'd0,  ST_FREE,    7'd0,   32'd10,        1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_RESCHED, 5'd0,  ST_FREE,    7'd0,   32'd20,        1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_UPDATE,  5'd5,  ST_READY,   7'd0,   32'd0,         1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_RESCHED, 5'd0,  ST_FREE,    7'd0,   32'd30,        1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_UPDATE,  5'd0,  ST_FREE,    7'd1,   32'd0,         1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_RESCHED, 5'd0,  ST_FREE,    7'd0,   32'd40,        1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_UPDATE,  5'd2,  ST_CURRENT, 7'd100, 32'd0,         1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_UPDATE,  5'd3,  ST_CURRENT, 7'd100, 32'd0,         1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_RESCHED, 5'd0,  ST_FREE,    7'd0,   32'd41,        1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_RESCHED, 5'd0,  ST_FREE,    7'd0,   32'd500,       1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_UPDATE,  5'd2,  ST_FREE,    7'd100, 32'd0,         1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_UPDATE,  5'd5,  ST_FREE,    7'd0,   32'd0,         1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_RESCHED, 5'd0,  ST_FREE,    7'd0,   32'd501,       1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_UPDATE,  5'd17, ST_READY,   7'd42,  32'd0,         1'b0, '{5'd0, 5'd0, 1'b0}},
            '{K_RESCHED, 5'd10, ST_READY,   7'd85,  32'h5555_AAAA, 1'b0, '{5'd0, 5'd0, 1'b0}}
        };
        idle_pct = '{0, 57, 6};

        for (k = 0; k < NUM_PROCS; k++) begin
            ps_state[k] = ST_FREE;
            ps_prio[k]  = 7'd1;
            tick_cnt[k] = '0;
            slice_q[k]  = '0;
        end
        ps_state[0] = ST_CURRENT;
        cur_pid     = '0;
        last_ms     = '0;
        clk_started = 1'b0;
        charge_en   = 1'b1;
        epoch_due   = 1'b1;
        sim_ms      = 32'd1000;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIR; k++) begin
            offer(dir_tab[k]);
        end

        for (ph = 0; ph < N_PHASE; ph++) begin
            for (k = 0; k < PER_PHASE; k++) begin
                n_gap = 0;
                while (n_gap < MAX_GAP && $urandom_range(99) < idle_pct[ph]) begin
                    n_gap++;
                end
                if (n_gap != 0) begin
                    start <= 1'b0;
                    while (n_gap != 0) begin
                        @(posedge i_clk);
                        if (!busy) begin
                            n_gap--;
                        end
                    end
                end

                r      = '0;
                r.kind = ($urandom_range(99) < 45) ? K_RESCHED : K_UPDATE;
                r.pid  = ($urandom_range(99) < 70) ? 5'($urandom_range(1, 7))
                                                   : 5'($urandom_range(31));
                sel = $urandom_range(99);
                if (sel < 45) begin
                    r.st = ST_READY;
                end else if (sel < 65) begin
                    r.st = ST_BLOCKED;
                end else if (sel < 85) begin
                    r.st = ST_FREE;
                end else begin
                    r.st = ST_CURRENT;
                end
                r.prio = ($urandom_range(99) < 3) ? 7'd0 : 7'($urandom_range(1, 127));
                sel = $urandom_range(99);
                if (sel < 85) begin
                    sim_ms = sim_ms + 32'($urandom_range(300));
                end else if (sel < 95) begin
                    sim_ms = sim_ms + 32'($urandom_range(3000));
                end else begin
                    sim_ms = $urandom;
                end
                r.now = sim_ms;
                offer(r);
            end
        end

        start <= 1'b0;
        while (pending_picks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * NUM_PROCS + 16) @(posedge i_clk);
        n_bad += pending_picks.size();

        $display("Covered %0d updates and %0d reschedules over %0d idle phases.",
                 n_upd, n_resched, N_PHASE);
        $display("Results compared: %0d, with %0d switches and %0d forced epochs; %0d errors.",
                 n_checked, n_switch, n_forced, n_bad);
        if (n_bad == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
